>>> hdl/mef_pkg.sv
// Package for the median-of-3 / EMA channel filter.
// Holds the command and status types, register and mode codes and the alpha table.
// No dependencies.
package mef_pkg;

  localparam int MAX_CH = 8;
  localparam int CH_W = 3;
  localparam int ALPHA_TABLE_SIZE = 256;
  localparam int ALPHA_SPAN = 8;
  localparam int QW = $clog2(ALPHA_TABLE_SIZE);
  localparam int SPAN_W = $clog2(ALPHA_SPAN);
  localparam int SHIFT = QW - SPAN_W;
  localparam int CNT_W = $clog2(QW);

  localparam logic signed [15:0] Q15_ONE = 16'sd32767;
  localparam logic signed [15:0] Q15_NEG_ONE = -16'sd32767;

  // Register indexes
  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_TYPES = 3'd1;
  localparam logic [2:0] REG_ENABLED = 3'd2;
  localparam logic [2:0] REG_TAU_LO = 3'd3;
  localparam logic [2:0] REG_TAU_HI = 3'd4;

  // Filter modes
  localparam logic [1:0] MODE_EMA = 2'd0;
  localparam logic [1:0] MODE_MED = 2'd1;
  localparam logic [1:0] MODE_DIAG = 2'd2;
  localparam logic [1:0] MODE_BAD = 2'd3;

  // Channel types
  localparam logic [1:0] TYPE_CENTERED = 2'd1;
  localparam logic [1:0] TYPE_ENCODER = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EVAL, ST_DIV, ST_MUL, ST_FIN, ST_PUSH
  } mef_state_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic div_step;
    logic mul;
    logic fin;
    logic push;
  } mef_cmd_t;

  typedef struct packed {
    logic eval_done;
    logic div_last;
  } mef_sts_t;

  typedef logic [15:0] alpha_tab_t [ALPHA_TABLE_SIZE];

  // Build 1 - exp(-span*k/size) in Q0.15 with 32.32 fixed point
  function automatic alpha_tab_t build_alpha();
    logic [63:0] one, x, term, pos, neg, q, e;
    alpha_tab_t t;
    one = 64'd1 << 32;
    x = (64'(ALPHA_SPAN) << 32) / ALPHA_TABLE_SIZE;
    term = one;
    pos = one;
    neg = 64'd0;
    for (int n = 1; n <= 16; n++) begin
      term = ((term * x) >> 32) / 64'(n);
      if (n % 2 == 1) neg = neg + term;
      else pos = pos + term;
    end
    q = pos - neg;
    e = one;
    for (int k = 0; k < ALPHA_TABLE_SIZE; k++) begin
      t[k] = 16'((one - e + (64'd1 << 16)) >> 17);
      e = (e * q + (64'd1 << 31)) >> 32;
    end
    return t;
  endfunction

  localparam alpha_tab_t ALPHA_TAB = build_alpha();

  function automatic logic signed [15:0] med3(input logic signed [15:0] a,
                                              input logic signed [15:0] b,
                                              input logic signed [15:0] c);
    logic signed [15:0] lo, hi, m;
    lo = (a > b) ? b : a;
    hi = (a > b) ? a : b;
    m = (hi > c) ? c : hi;
    if (lo > m) m = lo;
    return m;
  endfunction

endpackage

>>> hdl/median3_ema_channel_filter.sv
// Top level of the multi-channel median-of-3 / EMA input filter.
// Joins the controller mef_ctrl and the datapath mef_datapath; uses mef_pkg.
//
// Port group   Dir   Handshake            Payload
// in_          in    in_valid/in_ready    source, sample, elapsed_ms
// out_         out   out_valid/out_ready  value, source_ok
// cfg_         in    cfg_we               cfg_index, cfg_data (64 bits)
//
// Invalid, seeding and passthrough requests, and those with zero tau or elapsed_ms, skip the divide.
// Other EMA requests run the alpha index divide, one quotient bit a cycle, then multiply and finish.
// One request is in flight at a time; the output register lets the next request be
// accepted while a result waits. A stalled result holds the controller in its push
// state. Reset is synchronous and clears configuration and all channel state.
module median3_ema_channel_filter #(
  parameter int CHANNELS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         in_source,
  input  logic signed [15:0] in_sample,
  input  logic [15:0]        in_elapsed_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_value,
  output logic               out_source_ok
);
  import mef_pkg::*;

  mef_cmd_t cmd;
  mef_sts_t sts;

  mef_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  mef_datapath #(.CHANNELS(CHANNELS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_source(in_source), .in_sample(in_sample),
    .in_elapsed_ms(in_elapsed_ms), .out_value(out_value),
    .out_source_ok(out_source_ok), .cmd(cmd), .sts(sts)
  );

endmodule

>>> hdl/mef_ctrl.sv
// Controller of the channel filter: sequences load, evaluate, divide, multiply,
// finish and output push. Depends on mef_pkg.
module mef_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  mef_pkg::mef_sts_t sts,
  output mef_pkg::mef_cmd_t cmd
);
  import mef_pkg::*;

  mef_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  // State and output flag registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        state_nxt = sts.eval_done ? ST_PUSH : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.fin = 1'b1;
        state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        if (!out_valid_r || out_ready) begin
          cmd.push = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold the output valid until the result is taken
  always_comb begin
    if (cmd.push) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  assign out_valid = out_valid_r;

endmodule

>>> hdl/mef_datapath.sv
// Datapath of the channel filter: configuration, channel state, median, divider,
// EMA multiply and output register. Depends on mef_pkg.
module mef_datapath #(
  parameter int CHANNELS = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_index,
  input  logic [63:0]              cfg_data,
  input  logic [3:0]               in_source,
  input  logic signed [15:0]       in_sample,
  input  logic [15:0]              in_elapsed_ms,
  output logic signed [15:0]       out_value,
  output logic                     out_source_ok,
  input  mef_pkg::mef_cmd_t        cmd,
  output mef_pkg::mef_sts_t        sts
);
  import mef_pkg::*;

  localparam int RW = 16 + SHIFT;
  localparam int DVW = 16 + QW - 1;

  // Configuration
  logic [1:0]   mode_r;
  logic [15:0]  types_r;
  logic [7:0]   enabled_r;
  logic [127:0] tau_r;

  // Channel state
  logic signed [15:0] fv_r [MAX_CH];
  logic signed [15:0] hist_r [MAX_CH][3];
  logic [1:0]         ptr_r [MAX_CH];
  logic [MAX_CH-1:0]  started_r;

  // Request registers
  logic [3:0]         src_r;
  logic signed [15:0] smp_r;
  logic [15:0]        dt_r;

  // EMA working registers
  logic [CH_W-1:0]    ch_r;
  logic               cen_r;
  logic               sat_r;
  logic signed [15:0] fvo_r;
  logic signed [16:0] diff_r;
  logic [RW-1:0]      rem_r;
  logic [DVW-1:0]     dv_r;
  logic [QW-1:0]      q_r;
  logic [CNT_W-1:0]   cnt_r;
  logic signed [34:0] prod_r;
  logic signed [15:0] res_r;
  logic               res_ok_r;
  logic signed [15:0] out_value_r;
  logic               out_ok_r;

  // Evaluate the held request
  logic [3:0]         src_m1;
  logic [CH_W-1:0]    ch;
  logic               src_ok, centered, pass, started;
  logic [1:0]         ctype, p;
  logic signed [15:0] x, med, fin, fv;
  logic signed [15:0] h0, h1, h2;
  logic [15:0]        tau;
  logic               eval_done;
  logic signed [15:0] eval_res;
  logic               mode_chg;

  assign src_m1 = src_r - 4'd1;
  assign ch = src_m1[CH_W-1:0];
  assign src_ok = (src_r != 4'd0) && ({28'd0, src_r} <= 32'(CHANNELS)) && enabled_r[ch];
  assign ctype = types_r[2*ch +: 2];
  assign centered = (ctype == TYPE_CENTERED);
  assign started = started_r[ch];
  assign pass = (ctype == TYPE_ENCODER) || (mode_r == MODE_DIAG);
  assign p = (ptr_r[ch] > 2'd2) ? 2'd0 : ptr_r[ch];
  assign tau = tau_r[16*ch +: 16];
  assign fv = fv_r[ch];

  always_comb begin
    // Clamp to the channel range
    if (centered) x = (smp_r < Q15_NEG_ONE) ? Q15_NEG_ONE : smp_r;
    else x = (smp_r < 16'sd0) ? 16'sd0 : smp_r;
    // Median over the history with the new sample in place
    h0 = (p == 2'd0) ? x : hist_r[ch][0];
    h1 = (p == 2'd1) ? x : hist_r[ch][1];
    h2 = (p == 2'd2) ? x : hist_r[ch][2];
    med = med3(h0, h1, h2);
    fin = (mode_r == MODE_MED) ? med : x;
    eval_done = !src_ok || !started || pass || (tau == 16'd0) || (dt_r == 16'd0);
    if (!src_ok) eval_res = 16'sd0;
    else if (!started || pass) eval_res = x;
    else if (tau == 16'd0) eval_res = fin;
    else eval_res = fv;
  end

  assign mode_chg = cfg_we && (cfg_index == REG_MODE) && (cfg_data[1:0] != MODE_BAD) &&
                    (cfg_data[1:0] != mode_r);

  // EMA finish: round half away from zero, add and clamp
  logic [34:0]        mag;
  logic [34:0]        rnd;
  logic [18:0]        r19;
  logic signed [19:0] o_w;
  logic signed [15:0] o;
  logic [16:0]        alpha;
  logic signed [17:0] alpha_s;

  assign alpha = sat_r ? 17'd32768 : {1'b0, ALPHA_TAB[q_r]};
  assign alpha_s = {1'b0, alpha};

  always_comb begin
    mag = prod_r[34] ? 35'(-prod_r) : 35'(prod_r);
    rnd = (mag + 35'd16384) >> 15;
    r19 = rnd[18:0];
    o_w = {{4{fvo_r[15]}}, fvo_r} + (prod_r[34] ? -$signed({1'b0, r19}) :
                                                   $signed({1'b0, r19}));
    if (o_w > 20'(Q15_ONE)) o = Q15_ONE;
    else if (cen_r && (o_w < 20'(Q15_NEG_ONE))) o = Q15_NEG_ONE;
    else if (!cen_r && (o_w < 20'sd0)) o = 16'sd0;
    else o = o_w[15:0];
  end

  // Configuration and channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_EMA;
      types_r <= '0;
      enabled_r <= '0;
      tau_r <= '0;
      started_r <= '0;
      for (int c = 0; c < MAX_CH; c++) begin
        fv_r[c] <= '0;
        ptr_r[c] <= '0;
        for (int j = 0; j < 3; j++) hist_r[c][j] <= '0;
      end
    end else if (mode_chg) begin
      // Reseed every history from the filtered value
      mode_r <= cfg_data[1:0];
      for (int c = 0; c < MAX_CH; c++) begin
        ptr_r[c] <= '0;
        for (int j = 0; j < 3; j++) hist_r[c][j] <= fv_r[c];
      end
    end else if (cfg_we && (cfg_index == REG_TYPES || cfg_index == REG_ENABLED ||
                            cfg_index == REG_TAU_LO || cfg_index == REG_TAU_HI)) begin
      if (cfg_index == REG_TYPES) types_r <= cfg_data[15:0];
      if (cfg_index == REG_ENABLED) enabled_r <= cfg_data[7:0];
      if (cfg_index == REG_TAU_LO) tau_r[63:0] <= cfg_data;
      if (cfg_index == REG_TAU_HI) tau_r[127:64] <= cfg_data;
      started_r <= '0;
      for (int c = 0; c < MAX_CH; c++) begin
        fv_r[c] <= '0;
        ptr_r[c] <= '0;
        for (int j = 0; j < 3; j++) hist_r[c][j] <= '0;
      end
    end else if (cmd.eval && src_ok) begin
      if (!started) begin
        fv_r[ch] <= x;
        for (int j = 0; j < 3; j++) hist_r[ch][j] <= x;
        started_r[ch] <= 1'b1;
      end else if (pass) begin
        fv_r[ch] <= x;
      end else begin
        if (mode_r == MODE_MED) begin
          hist_r[ch][p] <= x;
          ptr_r[ch] <= (p == 2'd2) ? 2'd0 : p + 2'd1;
        end
        if (tau == 16'd0) fv_r[ch] <= fin;
      end
    end else if (cmd.fin) begin
      fv_r[ch_r] <= o;
    end
  end

  // Request, divider, multiplier and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      src_r <= in_source;
      smp_r <= in_sample;
      dt_r <= in_elapsed_ms;
    end
    if (cmd.eval) begin
      ch_r <= ch;
      cen_r <= centered;
      fvo_r <= fv;
      diff_r <= {fin[15], fin} - {fv[15], fv};
      // Index saturates once dt reaches span times tau
      sat_r <= {{SPAN_W{1'b0}}, dt_r} >= {tau, {SPAN_W{1'b0}}};
      rem_r <= {dt_r, {SHIFT{1'b0}}};
      dv_r <= {tau, {(QW-1){1'b0}}};
      q_r <= '0;
      cnt_r <= '0;
      res_r <= eval_res;
      res_ok_r <= src_ok;
    end
    // Restoring divide, one quotient bit a cycle
    if (cmd.div_step) begin
      if ({{(DVW-RW){1'b0}}, rem_r} >= dv_r) begin
        rem_r <= rem_r - dv_r[RW-1:0];
        q_r <= {q_r[QW-2:0], 1'b1};
      end else begin
        q_r <= {q_r[QW-2:0], 1'b0};
      end
      dv_r <= dv_r >> 1;
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.mul) prod_r <= diff_r * alpha_s;
    if (cmd.fin) res_r <= o;
    if (cmd.push) begin
      out_value_r <= res_r;
      out_ok_r <= res_ok_r;
    end
  end

  assign sts.eval_done = eval_done;
  assign sts.div_last = (cnt_r == CNT_W'(QW-1));
  assign out_value = out_value_r;
  assign out_source_ok = out_ok_r;

endmodule

>>> hdl/mef_checker.sv
// Port-level checks for the channel filter, bound to the top level.
// Depends on median3_ema_channel_filter ports only.
module mef_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_value,
  input logic               out_source_ok
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

  // Drop the value for a rejected source
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_source_ok |-> out_value == 16'sd0) else $error("nonzero value");

  // Never show the most negative code
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_value != 16'sh8000) else $error("value out of range");

  // Take one request at a time
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("request overlap");

  // No result straight after reset
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result after reset");

endmodule

bind median3_ema_channel_filter mef_checker u_mef_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_value(out_value),
  .out_source_ok(out_source_ok)
);

>>> sim/tb_top.sv
// Self-checking testbench for median3_ema_channel_filter.
// Predicts each result from a behavioural model of the filter and compares in order.
// Depends on mef_pkg and the filter RTL.
`timescale 1ns / 100ps

module tb_top;
  import mef_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [3:0] in_source = '0;
  logic signed [15:0] in_sample = '0;
  logic [15:0] in_elapsed_ms = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_value;
  logic out_source_ok;

  median3_ema_channel_filter dut (.*);

  typedef struct packed {
    logic signed [15:0] value;
    logic ok;
  } filt_res_t;

  // Model state and configuration
  logic [1:0] m_mode;
  logic [15:0] m_types;
  logic [7:0] m_enabled;
  logic [63:0] m_tau_lo, m_tau_hi;
  logic signed [15:0] m_filt [8];
  logic signed [15:0] m_hist [8][3];
  logic [1:0] m_ptr [8];
  logic m_started [8];
  logic [15:0] alpha_lut [ALPHA_TABLE_SIZE];

  filt_res_t pending_results [$];
  int mismatches = 0;
  int results_seen = 0;
  int requests_sent = 0;
  bit rx_stall_off = 1'b0;
  bit tx_idle_off = 1'b0;

  initial forever #2 clk = ~clk;

  initial begin
    #50ms;
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("[median3_ema_channel_filter] ERROR");
    $finish;
  end

  // Rebuild the alpha table with 32.32 fixed point series for exp
  task automatic make_alpha_lut();
    logic [63:0] one, x, term, pos, neg, q, e;
    one = 64'd1 << 32;
    x = (64'd8 << 32) / 64'd256;
    term = one; pos = one; neg = 0;
    for (int n = 1; n <= 16; n++) begin
      term = ((term * x) >> 32) / 64'(n);
      if (n % 2) neg += term;
      else pos += term;
    end
    q = pos - neg;
    e = one;
    for (int k = 0; k < ALPHA_TABLE_SIZE; k++) begin
      alpha_lut[k] = 16'((one - e + (64'd1 << 16)) >> 17);
      e = (e * q + (64'd1 << 31)) >> 32;
    end
  endtask

  task automatic clear_model_channels();
    for (int c = 0; c < 8; c++) begin
      m_filt[c] = 0; m_ptr[c] = 0; m_started[c] = 0;
      for (int j = 0; j < 3; j++) m_hist[c][j] = 0;
    end
  endtask

  function automatic int sat(int v, int lo);
    if (v < lo) return lo;
    if (v > 32767) return 32767;
    return v;
  endfunction

  function automatic int median_of(int a, int b, int c);
    int t;
    if (a > b) begin t = a; a = b; b = t; end
    if (b > c) b = c;
    if (a > b) b = a;
    return b;
  endfunction

  // Work out the filtered result of one request and update model state
  task automatic filter_request(input logic [3:0] src, input logic signed [15:0] smp,
                                input logic [15:0] dt, output filt_res_t r);
    int ch, lo, x, fin, o;
    logic [1:0] ty;
    logic [15:0] tau;
    longint idx, alpha, prod, mag, rr;
    r = '0;
    if (src == 0 || src > 8 || !m_enabled[src-1]) return;
    ch = src - 1;
    ty = m_types[2*ch +: 2];
    lo = (ty == TYPE_CENTERED) ? -32767 : 0;
    x = sat(int'(smp), lo);
    r.ok = 1'b1;
    if (!m_started[ch]) begin
      m_filt[ch] = 16'(x);
      for (int j = 0; j < 3; j++) m_hist[ch][j] = 16'(x);
      m_started[ch] = 1'b1;
      r.value = 16'(x);
    end else if (ty == TYPE_ENCODER || m_mode == MODE_DIAG) begin
      m_filt[ch] = 16'(x);
      r.value = 16'(x);
    end else begin
      fin = x;
      if (m_mode == MODE_MED) begin
        if (m_ptr[ch] > 2) m_ptr[ch] = 0;
        m_hist[ch][m_ptr[ch]] = 16'(x);
        m_ptr[ch] = (m_ptr[ch] == 2) ? 2'd0 : m_ptr[ch] + 2'd1;
        fin = median_of(m_hist[ch][0], m_hist[ch][1], m_hist[ch][2]);
      end
      tau = (ch < 4) ? m_tau_lo[16*ch +: 16] : m_tau_hi[16*(ch-4) +: 16];
      if (tau == 0) begin
        m_filt[ch] = 16'(fin);
        r.value = 16'(fin);
      end else if (dt == 0) begin
        r.value = m_filt[ch];
      end else begin
        idx = (longint'(dt) * 256) / (8 * longint'(tau));
        alpha = (idx >= 256) ? 32768 : longint'(alpha_lut[idx]);
        prod = longint'(fin - int'(m_filt[ch])) * alpha;
        mag = prod < 0 ? -prod : prod;
        rr = (mag + 16384) / 32768;
        o = int'(m_filt[ch]) + int'(prod < 0 ? -rr : rr);
        o = sat(o, lo);
        m_filt[ch] = 16'(o);
        r.value = 16'(o);
      end
    end
  endtask

  // Write one register into the block and the model; block must be idle
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MODE: begin
        if (data[1:0] != MODE_BAD && data[1:0] != m_mode) begin
          m_mode = data[1:0];
          for (int c = 0; c < 8; c++) begin
            for (int j = 0; j < 3; j++) m_hist[c][j] = m_filt[c];
            m_ptr[c] = 0;
          end
        end
      end
      REG_TYPES: begin m_types = data[15:0]; clear_model_channels(); end
      REG_ENABLED: begin m_enabled = data[7:0]; clear_model_channels(); end
      REG_TAU_LO: begin m_tau_lo = data; clear_model_channels(); end
      REG_TAU_HI: begin m_tau_hi = data; clear_model_channels(); end
      default: ;
    endcase
  endtask

  // Drop the request line, drain every outstanding result, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Send one request with a random lead-in gap; valid stays up for a gapless follower
  task automatic send_request(input logic [3:0] src, input logic signed [15:0] smp,
                              input logic [15:0] dt);
    filt_res_t r;
    int gap;
    gap = tx_idle_off ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1; in_source <= src; in_sample <= smp; in_elapsed_ms <= dt;
    do @(posedge clk); while (!in_ready);
    filter_request(src, smp, dt, r);
    pending_results.push_back(r);
    requests_sent++;
  endtask

  // Random sample biased towards range edges
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(-$urandom_range(0, 40));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_dt();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hffff;
      2: return 16'($urandom);
      default: return 16'($urandom_range(1, 300));
    endcase
  endfunction

  function automatic logic [15:0] pick_tau();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return 16'hffff;
      2: return 16'($urandom);
      default: return 16'($urandom_range(1, 200));
    endcase
  endfunction

  function automatic logic [63:0] pick_taus();
    return {pick_tau(), pick_tau(), pick_tau(), pick_tau()};
  endfunction

  // Result checker and receiver stall
  initial begin
    filt_res_t exp_r;
    int stall;
    forever begin
      stall = rx_stall_off ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready && rst_n));
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result value=%0d ok=%0b",
                                       out_value, out_source_ok);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_value !== exp_r.value || out_source_ok !== exp_r.ok) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected value=%0d ok=%0b, got value=%0d ok=%0b",
                     exp_r.value, exp_r.ok, out_value, out_source_ok);
        end
      end
    end
  end

  // Invalid and disabled sources, clamping extremes, seeding
  task automatic test_directed_edges();
    write_reg(REG_TYPES, 64'h0000_0000_0000_9a64);
    write_reg(REG_ENABLED, 64'h0000_0000_0000_007f);
    write_reg(REG_TAU_LO, {16'd0, 16'd10, 16'hffff, 16'd1});
    write_reg(REG_TAU_HI, {16'd5, 16'd0, 16'd100, 16'd3});
    send_request(4'd0, 16'sd100, 16'd5);
    send_request(4'd9, 16'sd100, 16'd5);
    send_request(4'd15, -16'sd1, 16'hffff);
    send_request(4'd8, 16'sd100, 16'd5);
    for (int s = 1; s <= 7; s++) send_request(4'(s), 16'sh8000, 16'd1);
    for (int s = 1; s <= 7; s++) send_request(4'(s), 16'sh7fff, 16'hffff);
    send_request(4'd2, -16'sd500, 16'd0);
    send_request(4'd1, 16'sd0, 16'd0);
    send_request(4'd3, 16'sd1000, 16'd7);
    send_request(4'd4, -16'sd32767, 16'd3);
    drain();
  endtask

  // Each mode, including a rejected write and repeating the current one
  task automatic test_modes();
    logic [1:0] modes [5] = '{MODE_MED, MODE_MED, MODE_BAD, MODE_DIAG, MODE_EMA};
    write_reg(REG_ENABLED, 64'hff);
    foreach (modes[i]) begin
      write_reg(REG_MODE, {62'd0, modes[i]});
      for (int n = 0; n < 40; n++)
        send_request(4'($urandom_range(1, 8)), pick_sample(), pick_dt());
      drain();
    end
  endtask

  // Long random phases with fresh calibration; one phase at full rate
  task automatic test_random_phases();
    for (int ph = 0; ph < 12; ph++) begin
      tx_idle_off = (ph == 3);
      rx_stall_off = (ph == 3 || ph == 7);
      write_reg(REG_MODE, 64'($urandom_range(0, 3)));
      if (ph == 0) write_reg(REG_TYPES, 64'hffff);
      else write_reg(REG_TYPES, 64'($urandom));
      write_reg(REG_ENABLED, (ph == 1) ? 64'h0 : ($urandom_range(0, 3) == 0 ?
                                                   64'($urandom) : 64'hff));
      write_reg(REG_TAU_LO, pick_taus());
      write_reg(REG_TAU_HI, pick_taus());
      // Mode change mid-phase reseeds histories from the filtered values
      for (int n = 0; n < 125; n++) begin
        if ($urandom_range(0, 9) == 0)
          send_request(4'($urandom_range(0, 15)), pick_sample(), pick_dt());
        else
          send_request(4'($urandom_range(1, 8)), pick_sample(), pick_dt());
      end
      drain();
      write_reg(REG_MODE, 64'($urandom_range(0, 2)));
      write_reg(3'($urandom_range(5, 7)), 64'($urandom));
      for (int n = 0; n < 5; n++)
        send_request(4'($urandom_range(1, 8)), pick_sample(), pick_dt());
      drain();
    end
    tx_idle_off = 0;
    rx_stall_off = 0;
  endtask

  initial begin
    make_alpha_lut();
    m_mode = 0; m_types = 0; m_enabled = 0; m_tau_lo = 0; m_tau_hi = 0;
    clear_model_channels();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_edges();
    test_modes();
    test_random_phases();
    drain();
    $display("Sent %0d requests over all modes, channel types and tau extremes;",
             requests_sent);
    $display("checked %0d results, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("[median3_ema_channel_filter] OK");
    else
      $display("[median3_ema_channel_filter] ERROR");
    $finish;
  end

endmodule
